// ===== design/qsp_pkg.sv =====
// ----------------------------------------------------------------------------
// qsp_pkg
// Shared types, codes and keyword tables of the QCIR-G14 stream parser.
// ----------------------------------------------------------------------------
package qsp_pkg;

  localparam int LINE_BITS_DEF = 24;
  localparam int OUT_LINE_W    = 24;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = 2;
  localparam int QCNT_W        = 3;
  localparam int MAX_PER_BYTE  = 2;
  localparam int STEP_LIMIT    = 8;

  // parse phases, one-hot
  typedef enum logic [26:0] {
    PH_HDR       = 27'b1 << 0,
    PH_HASH      = 27'b1 << 1,
    PH_G         = 27'b1 << 2,
    PH_SKIPLINE  = 27'b1 << 3,
    PH_FREE      = 27'b1 << 4,
    PH_FR        = 27'b1 << 5,
    PH_QUANT     = 27'b1 << 6,
    PH_OUT       = 27'b1 << 7,
    PH_KW        = 27'b1 << 8,
    PH_VL_OPEN   = 27'b1 << 9,
    PH_VL_ITEM   = 27'b1 << 10,
    PH_VL_SEP    = 27'b1 << 11,
    PH_NL_QUANT  = 27'b1 << 12,
    PH_OUT_OPEN  = 27'b1 << 13,
    PH_OUT_LIT   = 27'b1 << 14,
    PH_OUT_CLOSE = 27'b1 << 15,
    PH_NL_OUT    = 27'b1 << 16,
    PH_VAR_START = 27'b1 << 17,
    PH_VAR_BODY  = 27'b1 << 18,
    PH_G_START   = 27'b1 << 19,
    PH_G_EQ      = 27'b1 << 20,
    PH_G_OP      = 27'b1 << 21,
    PH_G_OPEN    = 27'b1 << 22,
    PH_G_ITEM    = 27'b1 << 23,
    PH_G_SEP     = 27'b1 << 24,
    PH_NL_GATE   = 27'b1 << 25,
    PH_DONE      = 27'b1 << 26
  } phase_t;

  localparam logic [2:0] EV_QOPEN  = 3'd0;
  localparam logic [2:0] EV_NCHAR  = 3'd1;
  localparam logic [2:0] EV_NEND   = 3'd2;
  localparam logic [2:0] EV_QCLOSE = 3'd3;
  localparam logic [2:0] EV_GTYPE  = 3'd4;
  localparam logic [2:0] EV_GCLOSE = 3'd5;
  localparam logic [2:0] EV_FEND   = 3'd6;
  localparam logic [2:0] EV_ERROR  = 3'd7;

  localparam logic [2:0] ERR_KEYWORD  = 3'd0;
  localparam logic [2:0] ERR_EOF_KW   = 3'd1;
  localparam logic [2:0] ERR_EXP_CHAR = 3'd2;
  localparam logic [2:0] ERR_EXP_VAR  = 3'd3;
  localparam logic [2:0] ERR_GATE_OP  = 3'd4;
  localparam logic [2:0] ERR_NEWLINE  = 3'd5;

  localparam logic [1:0] QK_FREE   = 2'd0;
  localparam logic [1:0] QK_EXISTS = 2'd1;
  localparam logic [1:0] QK_FORALL = 2'd2;

  localparam logic [1:0] GK_AND = 2'd0;
  localparam logic [1:0] GK_OR  = 2'd1;
  localparam logic [1:0] GK_XOR = 2'd2;
  localparam logic [1:0] GK_ITE = 2'd3;

  localparam logic [1:0] ROLE_QVAR   = 2'd0;
  localparam logic [1:0] ROLE_OUTLIT = 2'd1;
  localparam logic [1:0] ROLE_GVAR   = 2'd2;
  localparam logic [1:0] ROLE_GLIT   = 2'd3;

  localparam logic [3:0] KW_QCIR   = 4'd0;
  localparam logic [3:0] KW_14     = 4'd1;
  localparam logic [3:0] KW_AND    = 4'd2;
  localparam logic [3:0] KW_OR     = 4'd3;
  localparam logic [3:0] KW_XOR    = 4'd4;
  localparam logic [3:0] KW_ITE    = 4'd5;
  localparam logic [3:0] KW_EXISTS = 4'd6;
  localparam logic [3:0] KW_FORALL = 4'd7;
  localparam logic [3:0] KW_FREE   = 4'd8;
  localparam logic [3:0] KW_OUTPUT = 4'd9;
  localparam logic [3:0] KW_COUNT  = 4'd10;

  typedef struct packed {
    logic [2:0]            ev;
    logic [1:0]            kind;
    logic [1:0]            role;
    logic [7:0]            ch;
    logic                  neg;
    logic [2:0]            code;
    logic [OUT_LINE_W-1:0] line;
    logic                  last;
  } res_t;

  function automatic logic [2:0] kw_len(input logic [3:0] id);
    logic [2:0] l;
    unique case (id)
      KW_QCIR:   l = 3'd5;
      KW_14:     l = 3'd2;
      KW_AND:    l = 3'd3;
      KW_OR:     l = 3'd2;
      KW_XOR:    l = 3'd3;
      KW_ITE:    l = 3'd3;
      KW_EXISTS: l = 3'd6;
      KW_FORALL: l = 3'd6;
      KW_FREE:   l = 3'd4;
      KW_OUTPUT: l = 3'd6;
      default:   l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] kw_char(input logic [3:0] id, input logic [2:0] pos);
    logic [47:0] s;
    int          idx;
    unique case (id)
      KW_QCIR:   s = 48'("qcir-");
      KW_14:     s = 48'("14");
      KW_AND:    s = 48'("and");
      KW_OR:     s = 48'("or");
      KW_XOR:    s = 48'("xor");
      KW_ITE:    s = 48'("ite");
      KW_EXISTS: s = 48'("exists");
      KW_FORALL: s = 48'("forall");
      KW_FREE:   s = 48'("free");
      KW_OUTPUT: s = 48'("output");
      default:   s = '0;
    endcase
    // strings are right aligned: first char sits highest
    idx = int'(kw_len(id)) - 1 - int'(pos);
    if (idx < 0 || idx > 5) begin
      return 8'd0;
    end
    return s[8*idx +: 8];
  endfunction

  function automatic res_t mk_res(input logic [2:0] ev, input logic [1:0] kind,
                                  input logic [1:0] role, input logic [7:0] ch,
                                  input logic neg, input logic [2:0] code,
                                  input logic [OUT_LINE_W-1:0] line);
    res_t r;
    r.ev   = ev;
    r.kind = kind;
    r.role = role;
    r.ch   = ch;
    r.neg  = neg;
    r.code = code;
    r.line = line;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

// ===== design/qsp_core.sv =====
// ----------------------------------------------------------------------------
// qsp_core
// Parser state and the per-byte transition: up to two results per byte.
// ----------------------------------------------------------------------------
module qsp_core
  import qsp_pkg::*;
#(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] byte_in,
  input  logic       at_eof,
  output res_t       res0,
  output res_t       res1,
  output logic [1:0] res_n
);

  localparam int EW = (LINE_BITS > OUT_LINE_W) ? LINE_BITS : OUT_LINE_W;
  localparam logic [EW-1:0] OUT_MAX = EW'({OUT_LINE_W{1'b1}});

  phase_t               ph_r, ph_nxt;
  logic [3:0]           kid_r, kid_nxt;
  logic [2:0]           kpos_r, kpos_nxt;
  logic                 cmt_r, cmt_nxt;
  logic                 hdr_r, hdr_nxt;
  logic                 neg_r, neg_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic                 err_r, err_nxt;
  logic [1:0]           role_r, role_nxt;
  logic [1:0]           qk_r, qk_nxt;
  logic [1:0]           gk_r, gk_nxt;
  logic                 cr_r, cr_nxt;

  logic [LINE_BITS-1:0] line_plus;
  logic [OUT_LINE_W-1:0] line_o_old, line_o_new;
  logic [EW-1:0]        ext_old, ext_new;

  logic [7:0] c, lc;
  logic       eof, nl, is_var, cr_c;
  logic       sk_sp, sk_hash, sk_body, sk_cend, sk_nl, skn, skb;
  logic       used, inc, sk_go, sk_blank, e_go;
  res_t       e_r, r0, r1;
  logic [1:0] n;
  logic [2:0] kp1;

  assign line_plus = (line_r == {LINE_BITS{1'b1}}) ? line_r : line_r + LINE_BITS'(1);
  assign ext_old   = EW'(line_r);
  assign ext_new   = EW'(line_plus);
  assign line_o_old = (ext_old > OUT_MAX) ? OUT_MAX[OUT_LINE_W-1:0] : ext_old[OUT_LINE_W-1:0];
  assign line_o_new = (ext_new > OUT_MAX) ? OUT_MAX[OUT_LINE_W-1:0] : ext_new[OUT_LINE_W-1:0];

  assign c      = byte_in;
  assign eof    = at_eof;
  assign lc     = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  assign nl     = (c == 8'h0a) || (c == 8'h0d);
  assign cr_c   = (c == 8'h0d);
  assign is_var = !eof && ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                           (c >= "A" && c <= "Z") || c == "_");

  always_comb begin
    ph_nxt   = ph_r;
    kid_nxt  = kid_r;
    kpos_nxt = kpos_r;
    cmt_nxt  = cmt_r;
    hdr_nxt  = hdr_r;
    neg_nxt  = neg_r;
    err_nxt  = err_r;
    role_nxt = role_r;
    qk_nxt   = qk_r;
    gk_nxt   = gk_r;
    cr_nxt   = cr_r;
    used     = 1'b0;
    inc      = 1'b0;
    n        = 2'd0;
    r0       = '0;
    r1       = '0;
    sk_sp = 1'b0; sk_hash = 1'b0; sk_body = 1'b0; sk_cend = 1'b0; sk_nl = 1'b0;
    skn = 1'b0; skb = 1'b0; sk_go = 1'b0; sk_blank = 1'b0;
    e_go = 1'b0;
    e_r  = '0;
    kp1  = '0;

    if (acc && !err_r && ph_r != PH_DONE) begin
      if (cr_r) begin
        cr_nxt = 1'b0;
        // LF after CR belongs to the same line end
        if (!eof && c == 8'h0a) used = 1'b1;
      end
      for (int i = 0; i < STEP_LIMIT; i++) begin
        if (!used && !err_nxt && ph_nxt != PH_DONE) begin
          sk_sp    = !eof && !cmt_nxt && (c == " " || c == 8'h09);
          sk_hash  = !eof && !cmt_nxt && (c == "#");
          sk_body  = !eof && cmt_nxt && !nl;
          sk_cend  = !eof && cmt_nxt && nl;
          sk_nl    = !eof && !cmt_nxt && nl;
          skn      = sk_sp || sk_hash || sk_body || sk_cend;
          skb      = skn || sk_nl;
          sk_go    = 1'b0;
          sk_blank = 1'b0;
          e_go     = 1'b0;
          e_r      = '0;
          kp1      = kpos_nxt + 3'd1;

          unique case (ph_nxt)
            PH_HDR: begin
              if (!hdr_nxt && !eof && c == "#") begin
                used = 1'b1; ph_nxt = PH_HASH;
              end else ph_nxt = PH_FREE;
            end
            PH_HASH: begin
              if (!eof && c == "Q") begin
                kid_nxt = KW_QCIR; kpos_nxt = 3'd0; ph_nxt = PH_KW;
              end else ph_nxt = PH_SKIPLINE;
            end
            PH_G: begin
              if (!eof && lc == "g") used = 1'b1;
              kid_nxt = KW_14; kpos_nxt = 3'd0; ph_nxt = PH_KW;
            end
            PH_SKIPLINE: begin
              if (eof) ph_nxt = PH_HDR;
              else begin
                used = 1'b1;
                if (nl) begin
                  inc = 1'b1; cr_nxt = cr_c; ph_nxt = PH_HDR;
                end
              end
            end
            PH_FREE: begin
              if (skb) begin
                sk_go = 1'b1; sk_blank = 1'b1;
              end else if (!eof && lc == "f") begin
                used = 1'b1; ph_nxt = PH_FR;
              end else ph_nxt = PH_QUANT;
            end
            PH_FR: begin
              if (eof) begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_EOF_KW;
              end else if (lc == "r") begin
                kid_nxt = KW_FREE; kpos_nxt = 3'd1; ph_nxt = PH_KW;
              end else if (lc == "o") begin
                kid_nxt = KW_FORALL; kpos_nxt = 3'd1; ph_nxt = PH_KW;
              end else begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_KEYWORD;
              end
            end
            PH_QUANT: begin
              if (skb) begin
                sk_go = 1'b1; sk_blank = 1'b1;
              end else if (!eof && lc == "e") begin
                kid_nxt = KW_EXISTS; kpos_nxt = 3'd0; ph_nxt = PH_KW;
              end else if (!eof && lc == "f") begin
                kid_nxt = KW_FORALL; kpos_nxt = 3'd0; ph_nxt = PH_KW;
              end else ph_nxt = PH_OUT;
            end
            PH_OUT: begin
              if (skb) begin
                sk_go = 1'b1; sk_blank = 1'b1;
              end else if (eof) begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_EOF_KW;
              end else begin
                kid_nxt = KW_OUTPUT; kpos_nxt = 3'd0; ph_nxt = PH_KW;
              end
            end
            PH_KW: begin
              if (eof) begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_EOF_KW;
              end else if (kid_nxt >= KW_COUNT || kpos_nxt >= kw_len(kid_nxt) ||
                           lc != kw_char(kid_nxt, kpos_nxt)) begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_KEYWORD;
              end else begin
                used = 1'b1;
                kpos_nxt = kp1;
                if (kp1 == kw_len(kid_nxt)) begin
                  unique case (kid_nxt)
                    KW_QCIR: ph_nxt = PH_G;
                    KW_14: begin
                      hdr_nxt = 1'b1; ph_nxt = PH_SKIPLINE;
                    end
                    KW_AND, KW_OR, KW_XOR, KW_ITE: begin
                      gk_nxt = (kid_nxt == KW_AND) ? GK_AND :
                               (kid_nxt == KW_OR)  ? GK_OR  :
                               (kid_nxt == KW_XOR) ? GK_XOR : GK_ITE;
                      e_go = 1'b1; e_r.ev = EV_GTYPE; e_r.kind = gk_nxt;
                      ph_nxt = PH_G_OPEN;
                    end
                    KW_EXISTS, KW_FORALL, KW_FREE: begin
                      qk_nxt = (kid_nxt == KW_EXISTS) ? QK_EXISTS :
                               (kid_nxt == KW_FORALL) ? QK_FORALL : QK_FREE;
                      e_go = 1'b1; e_r.ev = EV_QOPEN; e_r.kind = qk_nxt;
                      ph_nxt = PH_VL_OPEN;
                    end
                    default: ph_nxt = PH_OUT_OPEN;
                  endcase
                end
              end
            end
            PH_VL_OPEN, PH_OUT_OPEN, PH_G_OPEN: begin
              if (skn) sk_go = 1'b1;
              else if (!eof && c == "(") begin
                used = 1'b1;
                ph_nxt = (ph_nxt == PH_VL_OPEN)  ? PH_VL_ITEM :
                         (ph_nxt == PH_OUT_OPEN) ? PH_OUT_LIT : PH_G_ITEM;
              end else begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_EXP_CHAR;
              end
            end
            PH_VL_ITEM: begin
              if (skn) sk_go = 1'b1;
              else if (!eof && c == ")") begin
                used = 1'b1; ph_nxt = PH_NL_QUANT;
              end else begin
                role_nxt = ROLE_QVAR; ph_nxt = PH_VAR_START;
              end
            end
            PH_VL_SEP: begin
              if (skn) sk_go = 1'b1;
              else if (!eof && c == ")") ph_nxt = PH_VL_ITEM;
              else if (!eof && c == ",") begin
                used = 1'b1; ph_nxt = PH_VL_ITEM;
              end else begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_EXP_CHAR;
              end
            end
            PH_NL_QUANT, PH_NL_OUT, PH_NL_GATE: begin
              if (sk_cend || (!skn && !eof && nl)) begin
                used = 1'b1; inc = 1'b1; cr_nxt = cr_c;
                if (sk_cend) cmt_nxt = 1'b0;
              end else if (skn) sk_go = 1'b1;
              if (sk_cend || (!skn && (eof || nl))) begin
                if (ph_nxt == PH_NL_QUANT) begin
                  e_go = 1'b1; e_r.ev = EV_QCLOSE; e_r.kind = qk_nxt;
                  ph_nxt = PH_QUANT;
                end else ph_nxt = PH_G_START;
              end else if (!skn) begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_NEWLINE;
              end
            end
            PH_OUT_LIT, PH_G_ITEM: begin
              if (skn) sk_go = 1'b1;
              else if (ph_nxt == PH_G_ITEM && !eof && c == ")") begin
                used = 1'b1;
                e_go = 1'b1; e_r.ev = EV_GCLOSE; e_r.kind = gk_nxt;
                ph_nxt = PH_NL_GATE;
              end else begin
                role_nxt = (ph_nxt == PH_OUT_LIT) ? ROLE_OUTLIT : ROLE_GLIT;
                if (!eof && c == "-") begin
                  used = 1'b1; neg_nxt = 1'b1;
                end
                ph_nxt = PH_VAR_START;
              end
            end
            PH_OUT_CLOSE: begin
              if (skn) sk_go = 1'b1;
              else if (!eof && c == ")") begin
                used = 1'b1; ph_nxt = PH_NL_OUT;
              end else begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_EXP_CHAR;
              end
            end
            PH_VAR_START: begin
              if (skn) sk_go = 1'b1;
              else if (is_var) begin
                used = 1'b1;
                e_go = 1'b1; e_r.ev = EV_NCHAR; e_r.role = role_nxt;
                e_r.ch = c; e_r.neg = neg_nxt;
                ph_nxt = PH_VAR_BODY;
              end else begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_EXP_VAR;
              end
            end
            PH_VAR_BODY: begin
              e_go = 1'b1; e_r.role = role_nxt; e_r.neg = neg_nxt;
              if (is_var) begin
                used = 1'b1; e_r.ev = EV_NCHAR; e_r.ch = c;
              end else begin
                e_r.ev = EV_NEND;
                neg_nxt = 1'b0;
                case (role_nxt)
                  ROLE_QVAR:   ph_nxt = PH_VL_SEP;
                  ROLE_OUTLIT: ph_nxt = PH_OUT_CLOSE;
                  ROLE_GVAR:   ph_nxt = PH_G_EQ;
                  default:     ph_nxt = PH_G_SEP;
                endcase
              end
            end
            PH_G_START: begin
              if (skb) begin
                sk_go = 1'b1; sk_blank = 1'b1;
              end else if (eof) begin
                e_go = 1'b1; e_r.ev = EV_FEND; ph_nxt = PH_DONE;
              end else begin
                role_nxt = ROLE_GVAR; ph_nxt = PH_VAR_START;
              end
            end
            PH_G_EQ: begin
              if (skn) sk_go = 1'b1;
              else if (!eof && c == "=") begin
                used = 1'b1; ph_nxt = PH_G_OP;
              end else begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_EXP_CHAR;
              end
            end
            PH_G_OP: begin
              kpos_nxt = 3'd0;
              if (skn) sk_go = 1'b1;
              else if (!eof && lc == "a") begin
                kid_nxt = KW_AND; ph_nxt = PH_KW;
              end else if (!eof && lc == "o") begin
                kid_nxt = KW_OR; ph_nxt = PH_KW;
              end else if (!eof && lc == "x") begin
                kid_nxt = KW_XOR; ph_nxt = PH_KW;
              end else if (!eof && lc == "i") begin
                kid_nxt = KW_ITE; ph_nxt = PH_KW;
              end else begin
                e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_GATE_OP;
              end
            end
            PH_G_SEP: begin
              if (skn) sk_go = 1'b1;
              else begin
                if (!eof && c == ",") used = 1'b1;
                ph_nxt = PH_G_ITEM;
              end
            end
            default: begin
              e_go = 1'b1; e_r.ev = EV_ERROR; e_r.code = ERR_KEYWORD;
            end
          endcase

          if (sk_go) begin
            used = 1'b1;
            if (sk_hash) cmt_nxt = 1'b1;
            if (sk_cend) begin
              cmt_nxt = 1'b0; inc = 1'b1; cr_nxt = cr_c;
            end
            if (sk_blank && sk_nl) begin
              inc = 1'b1; cr_nxt = cr_c;
            end
          end

          if (e_go) begin
            if (e_r.ev == EV_ERROR) err_nxt = 1'b1;
            e_r.line = inc ? line_o_new : line_o_old;
            if (n == 2'd0) r0 = e_r;
            else r1 = e_r;
            n = n + 2'd1;
          end
        end
      end
      if (n == 2'd1) r0.last = 1'b1;
      if (n == 2'd2) r1.last = 1'b1;
    end
  end

  assign line_nxt = inc ? line_plus : line_r;
  assign res0  = r0;
  assign res1  = r1;
  assign res_n = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_HDR;
      kid_r  <= '0;
      kpos_r <= '0;
      cmt_r  <= 1'b0;
      hdr_r  <= 1'b0;
      neg_r  <= 1'b0;
      line_r <= LINE_BITS'(1);
      err_r  <= 1'b0;
      role_r <= '0;
      qk_r   <= '0;
      gk_r   <= '0;
      cr_r   <= 1'b0;
    end else if (acc) begin
      ph_r   <= ph_nxt;
      kid_r  <= kid_nxt;
      kpos_r <= kpos_nxt;
      cmt_r  <= cmt_nxt;
      hdr_r  <= hdr_nxt;
      neg_r  <= neg_nxt;
      line_r <= line_nxt;
      err_r  <= err_nxt;
      role_r <= role_nxt;
      qk_r   <= qk_nxt;
      gk_r   <= gk_nxt;
      cr_r   <= cr_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_quiet_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r || ph_r == PH_DONE) |-> res_n == 2'd0)
    else $error("result after error or file end");
  a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> line_r >= $past(line_r))
    else $error("line count went backwards");
  a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    res_n == 2'd2 |-> res0.ev != EV_ERROR)
    else $error("result after error in same request");
`endif

endmodule

// ===== design/qsp_res_queue.sv =====
// ----------------------------------------------------------------------------
// qsp_res_queue
// Small result queue: takes up to two results a cycle, hands out one.
// ----------------------------------------------------------------------------
module qsp_res_queue
  import qsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       res0,
  input  res_t       res1,
  input  logic [1:0] res_n,
  output logic       room,
  output logic       q_valid,
  input  logic       q_ready,
  output res_t       q_data
);

  res_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign q_valid = (cnt_r != '0);
  assign q_data  = mem[rp_r];
  assign pop     = q_valid && q_ready;
  assign room    = (cnt_r <= QCNT_W'(QUEUE_DEPTH - MAX_PER_BYTE));
  assign wp_nxt  = wp_r + QPTR_W'(res_n);
  assign rp_nxt  = rp_r + QPTR_W'(pop);
  assign cnt_nxt = cnt_r + QCNT_W'(res_n) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (res_n != 2'd0) mem[wp_r] <= res0;
    if (res_n == 2'd2) mem[wp_r + QPTR_W'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_n != 2'd0 |-> QCNT_W'(res_n) + cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_pop_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (res_n == 2'd0 && pop) |=> cnt_r == $past(cnt_r) - QCNT_W'(1))
    else $error("queue count lost a pop");
`endif

endmodule

// ===== design/qcir_stream_parser.sv =====
// ----------------------------------------------------------------------------
// qcir_stream_parser
// Streaming QCIR-G14 parser: one file byte in, parse events out.
// ----------------------------------------------------------------------------
// One byte (or the end-of-file marker, in_tuser[0]) is taken each cycle that
// in_tready is high; the whole per-byte transition resolves combinationally
// into the parser state registers; each byte yields zero, one or two events. Events
// pass through a four-entry queue and leave one per cycle, so sustained
// throughput is one byte per cycle while the output keeps up, and
// in_tready drops whenever fewer than two queue entries are free. After
// an error event or the file-end event the block swallows input silently
// until reset. There are no configuration registers.
module qcir_stream_parser
  import qsp_pkg::*;
#(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic [0:0]  in_tuser,   // [0] at_eof
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [1:0] role, [9:2] name_char, [10] negated,
                                  // [13:11] error_code, [37:14] line_number, rest 0
  output logic [4:0]  out_tuser,  // [2:0] event_res, [4:3] kind
  output logic        out_tlast   // last event of this request
);

  res_t       res0, res1, q_data;
  logic [1:0] res_n;
  logic       room, acc;

  assign in_tready = room;
  assign acc       = in_tvalid && room;

  qsp_core #(.LINE_BITS(LINE_BITS)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .byte_in (in_tdata),
    .at_eof  (in_tuser[0]),
    .res0    (res0),
    .res1    (res1),
    .res_n   (res_n)
  );

  qsp_res_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .res0    (res0),
    .res1    (res1),
    .res_n   (res_n),
    .room    (room),
    .q_valid (out_tvalid),
    .q_ready (out_tready),
    .q_data  (q_data)
  );

  assign out_tdata = {2'b00, q_data.line, q_data.code, q_data.neg, q_data.ch, q_data.role};
  assign out_tuser = {q_data.kind, q_data.ev};
  assign out_tlast = q_data.last;

endmodule
